FILE: hdl/xpc_pkg.sv
// Package for the chained XOR packet codec: word types and mode codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package xpc_pkg;

  localparam int unsigned ByteW = 8;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } xpc_mode_t;

  // One input word after unpacking
  typedef struct packed {
    xpc_mode_t        cmd;
    logic             first_byte;
    logic             last_byte;
    logic [ByteW-1:0] rand_key;
    logic [ByteW-1:0] data_byte;
  } xpc_item_t;

  // One result word before packing
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic [ByteW-1:0] payload_sum;
    logic             check_ok;
    logic             run_end;
  } xpc_res_t;

endpackage : xpc_pkg

`default_nettype wire

FILE: hdl/xpc_in_reg.sv
// Input register of the codec: holds one accepted word until the core takes it.
// Depends on xpc_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module xpc_in_reg
  import xpc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire xpc_item_t in_item,
  input  wire logic      take,        // core consumes the held word this cycle
  output logic           held_valid,
  output xpc_item_t      held_item
);

  logic      valid_r, valid_nxt;
  xpc_item_t item_r;

  // Room when empty or when the held word leaves this cycle
  assign in_tready = !valid_r || take;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule : xpc_in_reg

`default_nettype wire

FILE: hdl/xpc_core.sv
// Chain state and byte transform of the codec, plus the fixed key register.
// Depends on xpc_pkg for word types and mode codes.
`timescale 1ns / 1ps
`default_nettype none

module xpc_core
  import xpc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [ByteW-1:0] cfg_wr_data,
  input  wire logic             advance,   // held word is processed this cycle
  input  wire xpc_item_t        item,
  output xpc_res_t              res
);

  logic [ByteW-1:0] fixed_key_r;
  logic [ByteW-1:0] inner_r, inner_nxt;
  logic [ByteW-1:0] outer_r, outer_nxt;
  logic [ByteW-1:0] pos_r, pos_nxt;
  logic [ByteW-1:0] rkey_r, rkey_nxt;
  xpc_mode_t        mode_r, mode_nxt;
  logic [ByteW-1:0] chk_r, chk_nxt;
  logic [ByteW-1:0] sum_r, sum_nxt;

  // A first byte restarts the run from cleared chains
  logic [ByteW-1:0] inner_cur, outer_cur, pos_cur;
  logic [ByteW-1:0] step, inner_mask, outer_mask, plain, result, q;

  assign inner_cur = item.first_byte ? '0 : inner_r;
  assign outer_cur = item.first_byte ? '0 : outer_r;
  assign pos_cur   = item.first_byte ? '0 : pos_r;
  assign rkey_nxt  = item.first_byte ? item.rand_key : rkey_r;
  assign mode_nxt  = item.first_byte ? item.cmd : mode_r;

  assign step       = pos_cur + ByteW'(1);
  assign inner_mask = inner_cur + rkey_nxt + step;
  assign outer_mask = outer_cur + fixed_key_r + step;
  assign q          = item.data_byte ^ outer_mask;

  // Transform: encode runs both chains forward, decode peels them in reverse
  always_comb begin
    case (mode_nxt)
      MODE_ENCODE: begin
        plain     = item.data_byte;
        inner_nxt = item.data_byte ^ inner_mask;
        outer_nxt = inner_nxt ^ outer_mask;
        result    = outer_nxt;
      end
      MODE_DECODE: begin
        plain     = q ^ inner_mask;
        inner_nxt = q;
        outer_nxt = item.data_byte;
        result    = plain;
      end
      default: begin
        plain     = item.data_byte;
        inner_nxt = inner_cur;
        outer_nxt = outer_cur;
        result    = item.data_byte;
      end
    endcase
  end

  // Checksum byte on first, payload sum otherwise
  assign chk_nxt = item.first_byte ? plain : chk_r;
  assign sum_nxt = item.first_byte ? '0 : sum_r + plain;
  assign pos_nxt = step;

  assign res.out_byte    = result;
  assign res.payload_sum = sum_nxt;
  assign res.check_ok    = item.last_byte && (chk_nxt == sum_nxt);
  assign res.run_end     = item.last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_key_r <= '0;
    end else if (cfg_wr_en) begin
      fixed_key_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_r <= '0;
      outer_r <= '0;
      pos_r   <= '0;
      rkey_r  <= '0;
      mode_r  <= MODE_ENCODE;
      chk_r   <= '0;
      sum_r   <= '0;
    end else if (advance) begin
      inner_r <= inner_nxt;
      outer_r <= outer_nxt;
      pos_r   <= pos_nxt;
      rkey_r  <= rkey_nxt;
      mode_r  <= mode_nxt;
      chk_r   <= chk_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule : xpc_core

`default_nettype wire

FILE: hdl/chained_xor_packet_codec.sv
// Top level of the chained XOR packet codec: stream ports, result register.
// Depends on xpc_pkg, xpc_in_reg and xpc_core.
//
//  channel  dir  handshake           payload
//  in_      in   in_tvalid/tready    tdata{data_byte,rand_key} tuser{first,cmd} tlast
//  out_     out  out_tvalid/tready   tdata{payload_sum,out_byte} tuser{check_ok} tlast
//  cfg_     in   cfg_wr_en           cfg_wr_data = fixed_key
//
// One word per cycle while out_tready is high; out_tvalid is the result register's valid.
// The chain update (two 8-bit adds and XORs per stage) sits between the input
// register and the result register; chain state advances when a word moves on.
// A stalled output holds its word while one more input word waits in the input register.
// Synchronous active-low reset clears valids, chains, counter, keys and mode.
`timescale 1ns / 1ps
`default_nettype none

module chained_xor_packet_codec
  import xpc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [7:0] rand_key, [15:8] data_byte
  input  wire logic [1:0]  in_tuser,   // [0] cmd, [1] first_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] out_byte, [15:8] payload_sum
  output logic             out_tuser,  // check_ok
  output logic             out_tlast,  // run_end
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  xpc_item_t in_item, held_item;
  xpc_res_t  res;
  xpc_res_t  res_r;
  logic      held_valid, advance;
  logic      out_valid_r, out_valid_nxt;

  assign in_item.cmd        = xpc_mode_t'(in_tuser[0]);
  assign in_item.first_byte = in_tuser[1];
  assign in_item.last_byte  = in_tlast;
  assign in_item.rand_key   = in_tdata[7:0];
  assign in_item.data_byte  = in_tdata[15:8];

  // Held word moves on when the result register is free or being drained
  assign advance = held_valid && (!out_valid_r || out_tready);

  xpc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  xpc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .advance     (advance),
    .item        (held_item),
    .res         (res)
  );

  // Result register
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.payload_sum, res_r.out_byte};
  assign out_tuser  = res_r.check_ok;
  assign out_tlast  = res_r.run_end;

  // A good checksum verdict only comes with the end of a run
  a_ok_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser || out_tlast))
    else $error("check_ok set on a word that does not end the run");

  // Input is never blocked while the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // The checksum byte of a run carries a zero payload sum
  a_first_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && held_item.first_byte) |=> (out_tdata[15:8] == 8'd0))
    else $error("nonzero payload sum on checksum byte");

  // Nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid following reset");

endmodule : chained_xor_packet_codec

`default_nettype wire
